// ===== design/tmrq_pkg.sv =====
// ----------------------------------------------------------------------------
// tmrq_pkg
// Shared types and constants of the tile map rectangle overlap query.
// ----------------------------------------------------------------------------
`default_nettype none

package tmrq_pkg;

    // command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // tile kinds; the fourth code has no meaning and is never stored
    localparam logic [1:0] KIND_EMPTY = 2'd0;
    localparam logic [1:0] KIND_WALL  = 2'd1;
    localparam logic [1:0] KIND_SPIKE = 2'd2;
    localparam logic [1:0] KIND_RSVD  = 2'd3;

    // index widths cover the largest grid (64 x 64)
    localparam int ROW_IDX_W  = 6;
    localparam int COL_IDX_W  = 6;
    localparam int MEM_ADDR_W = ROW_IDX_W + COL_IDX_W;
    localparam int IDX_CMP_W  = 7;

    // pixel edge sum: 10-bit coordinate plus 7-bit size
    localparam int SUM_W = 11;

    // at most eight rows and eight columns per query
    localparam logic [SUM_W-1:0] SPAN_LIMIT = 11'd8;

    typedef struct packed {
        logic                 empty;
        logic [ROW_IDX_W-1:0] row_lo;
        logic [ROW_IDX_W-1:0] row_hi;
        logic [COL_IDX_W-1:0] col_lo;
        logic [COL_IDX_W-1:0] col_hi;
    } t_span;

    typedef struct packed {
        logic                  we;
        logic [MEM_ADDR_W-1:0] waddr;
        logic [1:0]            wkind;
        logic                  re;
        logic [MEM_ADDR_W-1:0] raddr;
    } t_mem_req;

endpackage

`default_nettype wire

// ===== design/tmrq_in_if.sv =====
// ----------------------------------------------------------------------------
// tmrq_in_if
// Command channel: one write or query word per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface tmrq_in_if;
    logic       valid;
    logic       ready;
    logic       command;
    logic [3:0] write_row;
    logic [4:0] write_col;
    logic [1:0] write_kind;
    logic [9:0] rect_left;
    logic [9:0] rect_top;
    logic [6:0] rect_width;
    logic [6:0] rect_height;

    modport source (
        output valid, command, write_row, write_col, write_kind,
               rect_left, rect_top, rect_width, rect_height,
        input  ready
    );

    modport sink (
        input  valid, command, write_row, write_col, write_kind,
               rect_left, rect_top, rect_width, rect_height,
        output ready
    );
endinterface

`default_nettype wire

// ===== design/tmrq_out_if.sv =====
// ----------------------------------------------------------------------------
// tmrq_out_if
// Result channel: one covered tile per handshake.
// ----------------------------------------------------------------------------
`default_nettype none

interface tmrq_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] hit_row;
    logic [4:0] hit_col;
    logic [1:0] hit_kind;
    logic       last_hit;

    modport source (
        output valid, hit_row, hit_col, hit_kind, last_hit,
        input  ready
    );

    modport sink (
        input  valid, hit_row, hit_col, hit_kind, last_hit,
        output ready
    );
endinterface

`default_nettype wire

// ===== design/tmrq_grid_mem.sv =====
// ----------------------------------------------------------------------------
// tmrq_grid_mem
// Tile kind store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`default_nettype none

module tmrq_grid_mem #(
    parameter int AW = 9
) (
    input  wire logic               i_clk,
    input  wire tmrq_pkg::t_mem_req i_req,
    output logic [1:0]              o_rd_kind
);

    logic [1:0] r_grid [2**AW];
    logic [1:0] r_rd_kind;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_grid[i_req.waddr[AW-1:0]] <= i_req.wkind;
        end
    end

    // read data holds while re is low (output stall)
    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            r_rd_kind <= r_grid[i_req.raddr[AW-1:0]];
        end
    end

    assign o_rd_kind = r_rd_kind;

endmodule

`default_nettype wire

// ===== design/tmrq_span_calc.sv =====
// ----------------------------------------------------------------------------
// tmrq_span_calc
// Pixel rectangle to tile span: edge sums, reciprocal divide, clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module tmrq_span_calc #(
    parameter int GRID_ROWS   = 16,
    parameter int GRID_COLS   = 32,
    parameter int TILE_PIXELS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [9:0]  i_left,
    input  wire logic [9:0]  i_top,
    input  wire logic [6:0]  i_width,
    input  wire logic [6:0]  i_height,
    output logic             o_done,
    output tmrq_pkg::t_span  o_span
);

    localparam int SW     = tmrq_pkg::SUM_W;
    // exact divide by multiply: m = ceil(2^(n+l) / d), l = ceil(log2 d)
    localparam int DIV_L  = (TILE_PIXELS > 1) ? $clog2(TILE_PIXELS) : 0;
    localparam int DIV_S  = SW + DIV_L;
    localparam int DIV_M  = ((1 << DIV_S) + TILE_PIXELS - 1) / TILE_PIXELS;
    localparam int PROD_W = 2 * SW + 1;

    logic          r_a_valid, r_b_valid, r_c_valid;
    logic [SW-1:0] r_left_a, r_top_a, r_right_a, r_bottom_a;
    logic [PROD_W-1:0] r_left_p, r_top_p, r_right_p, r_bottom_p;
    tmrq_pkg::t_span   r_span;

    logic [SW-1:0] row_lo, col_lo, end_row, end_col, row_hi, col_hi;

    function automatic logic [SW-1:0] clamp_last(
        input logic [SW-1:0] first,
        input logic [SW-1:0] lastq,
        input logic [SW-1:0] cnt
    );
        logic [SW-1:0] lim;
        lim = (lastq >= cnt) ? cnt - SW'(1) : lastq;
        if (lim - first >= tmrq_pkg::SPAN_LIMIT) begin
            lim = first + tmrq_pkg::SPAN_LIMIT - SW'(1);
        end
        return lim;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
        end else begin
            r_a_valid <= i_start;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
        end
    end

    // stage a: edges (right and bottom inclusive)
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_left_a   <= SW'(i_left);
            r_top_a    <= SW'(i_top);
            r_right_a  <= SW'(i_left) + SW'(i_width);
            r_bottom_a <= SW'(i_top) + SW'(i_height);
        end
    end

    // stage b: reciprocal products
    always_ff @(posedge i_clk) begin
        if (r_a_valid) begin
            r_left_p   <= PROD_W'(r_left_a)   * PROD_W'(DIV_M);
            r_top_p    <= PROD_W'(r_top_a)    * PROD_W'(DIV_M);
            r_right_p  <= PROD_W'(r_right_a)  * PROD_W'(DIV_M);
            r_bottom_p <= PROD_W'(r_bottom_a) * PROD_W'(DIV_M);
        end
    end

    // stage c: quotients and clamps
    always_comb begin
        col_lo  = SW'(r_left_p >> DIV_S);
        row_lo  = SW'(r_top_p >> DIV_S);
        end_col = SW'(r_right_p >> DIV_S);
        end_row = SW'(r_bottom_p >> DIV_S);
        row_hi  = clamp_last(row_lo, end_row, SW'(GRID_ROWS));
        col_hi  = clamp_last(col_lo, end_col, SW'(GRID_COLS));
    end

    always_ff @(posedge i_clk) begin
        if (r_b_valid) begin
            r_span.empty  <= (row_lo >= SW'(GRID_ROWS)) ||
                             (col_lo >= SW'(GRID_COLS));
            r_span.row_lo <= row_lo[tmrq_pkg::ROW_IDX_W-1:0];
            r_span.row_hi <= row_hi[tmrq_pkg::ROW_IDX_W-1:0];
            r_span.col_lo <= col_lo[tmrq_pkg::COL_IDX_W-1:0];
            r_span.col_hi <= col_hi[tmrq_pkg::COL_IDX_W-1:0];
        end
    end

    assign o_done = r_c_valid;
    assign o_span = r_span;

endmodule

`default_nettype wire

// ===== design/tmrq_seq.sv =====
// ----------------------------------------------------------------------------
// tmrq_seq
// Sequencer: clear sweep, command handshake, tile scan and result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module tmrq_seq #(
    parameter int GRID_ROWS = 16,
    parameter int GRID_COLS = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    tmrq_in_if.sink                 i_in,
    tmrq_out_if.source              o_out,
    output logic                    o_calc_start,
    input  wire logic               i_span_done,
    input  wire tmrq_pkg::t_span    i_span,
    output tmrq_pkg::t_mem_req      o_mem_req,
    input  wire logic [1:0]         i_rd_kind
);

    localparam int RW  = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
    localparam int CW  = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;
    localparam int AW  = RW + CW;
    localparam int RIW = tmrq_pkg::ROW_IDX_W;
    localparam int CIW = tmrq_pkg::COL_IDX_W;
    localparam int CMW = tmrq_pkg::IDX_CMP_W;
    localparam int MAW = tmrq_pkg::MEM_ADDR_W;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_CALC  = 4'b0100,
        S_SCAN  = 4'b1000
    } t_state;

    t_state          r_state, n_state;
    logic [AW-1:0]   r_clr;
    tmrq_pkg::t_span r_span;
    logic [RIW-1:0]  r_row;
    logic [CIW-1:0]  r_col;
    logic            r_s1_valid;
    logic [RIW-1:0]  r_s1_row;
    logic [CIW-1:0]  r_s1_col;
    logic            r_s1_last;

    logic            accept, advance, issue, issue_last, wr_ok, is_query;
    logic [RIW-1:0]  w_row;
    logic [CIW-1:0]  w_col;

    assign i_in.ready = (r_state == S_IDLE);
    assign accept     = i_in.valid && i_in.ready;
    assign is_query   = (i_in.command == tmrq_pkg::CMD_QUERY);
    assign advance    = !r_s1_valid || o_out.ready;
    assign issue      = (r_state == S_SCAN) && advance;
    assign issue_last = (r_row == r_span.row_hi) && (r_col == r_span.col_hi);

    assign w_row = RIW'(i_in.write_row);
    assign w_col = CIW'(i_in.write_col);
    assign wr_ok = (i_in.command == tmrq_pkg::CMD_WRITE) &&
                   (CMW'(i_in.write_row) < CMW'(GRID_ROWS)) &&
                   (CMW'(i_in.write_col) < CMW'(GRID_COLS)) &&
                   (i_in.write_kind != tmrq_pkg::KIND_RSVD);

    assign o_calc_start = accept && is_query;

    always_comb begin
        o_mem_req.we    = (r_state == S_CLEAR) || (accept && wr_ok);
        o_mem_req.waddr = (r_state == S_CLEAR) ? MAW'(r_clr)
                                               : MAW'({w_row[RW-1:0], w_col[CW-1:0]});
        o_mem_req.wkind = (r_state == S_CLEAR) ? tmrq_pkg::KIND_EMPTY : i_in.write_kind;
        o_mem_req.re    = advance;
        o_mem_req.raddr = MAW'({r_row[RW-1:0], r_col[CW-1:0]});
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == {AW{1'b1}}) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept && is_query) n_state = S_CALC;
            end
            S_CALC: begin
                if (i_span_done) n_state = i_span.empty ? S_IDLE : S_SCAN;
            end
            S_SCAN: begin
                if (issue && issue_last) n_state = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) r_clr <= r_clr + AW'(1);
            if (advance) r_s1_valid <= issue;
        end
    end

    // scan counters, row by row, left to right
    always_ff @(posedge i_clk) begin
        if ((r_state == S_CALC) && i_span_done) begin
            r_span <= i_span;
            r_row  <= i_span.row_lo;
            r_col  <= i_span.col_lo;
        end else if (issue) begin
            if (r_col == r_span.col_hi) begin
                r_col <= r_span.col_lo;
                r_row <= r_row + RIW'(1);
            end else begin
                r_col <= r_col + CIW'(1);
            end
        end
    end

    // tags travel alongside the memory read data
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s1_row  <= r_row;
            r_s1_col  <= r_col;
            r_s1_last <= issue_last;
        end
    end

    assign o_out.valid    = r_s1_valid;
    assign o_out.hit_row  = r_s1_row[3:0];
    assign o_out.hit_col  = r_s1_col[4:0];
    assign o_out.hit_kind = i_rd_kind;
    assign o_out.last_hit = r_s1_last;

`ifndef SYNTH
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !r_s1_valid)
        else $error("result word during clear sweep");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (issue && issue_last) |=> (r_state == S_IDLE))
        else $error("scan went on past last tile");

    a_scan_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_row >= r_span.row_lo && r_row <= r_span.row_hi &&
                                 r_col >= r_span.col_lo && r_col <= r_span.col_hi))
        else $error("scan counter outside span");

    a_no_wr_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_req.we |-> (r_state == S_CLEAR || r_state == S_IDLE))
        else $error("grid write during query");
`endif

endmodule

`default_nettype wire

// ===== design/tile_map_rect_overlap_query.sv =====
// ----------------------------------------------------------------------------
// tile_map_rect_overlap_query
// Tile grid store with rectangle overlap query. The grid (GRID_ROWS by
// GRID_COLS kinds: empty, wall, spike) lives in one synchronous memory. After
// reset a clear sweep writes empty to every entry, 2^(clog2(GRID_ROWS) +
// clog2(GRID_COLS)) of them (512 at the defaults); no command word is taken
// until it ends. A write word is stored when accepted; writes outside the
// grid and of the meaningless fourth kind are dropped. A query word turns the
// pixel rectangle into a tile span (edge sums, reciprocal multiply for the
// divide by TILE_PIXELS, clamp to the grid and to eight by eight), then
// reads one covered tile per cycle, 1 to 64, set by the single read port of
// the grid memory; a query that starts off the grid gives no result word.
// Result words come row by row, left to right, with last_hit on the final
// one. Output stalls hold the scan. A new command is taken as soon as the
// last tile has been read, even while the final result word still waits.
// ----------------------------------------------------------------------------
`default_nettype none

module tile_map_rect_overlap_query #(
    parameter int GRID_ROWS   = 16,
    parameter int GRID_COLS   = 32,
    parameter int TILE_PIXELS = 16
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    tmrq_in_if.sink    i_in,
    tmrq_out_if.source o_out
);

    localparam int RW = (GRID_ROWS > 1) ? $clog2(GRID_ROWS) : 1;
    localparam int CW = (GRID_COLS > 1) ? $clog2(GRID_COLS) : 1;

    logic               calc_start;
    logic               span_done;
    tmrq_pkg::t_span    span;
    tmrq_pkg::t_mem_req mem_req;
    logic [1:0]         rd_kind;

    // pixel rectangle -> tile span
    tmrq_span_calc #(
        .GRID_ROWS   (GRID_ROWS),
        .GRID_COLS   (GRID_COLS),
        .TILE_PIXELS (TILE_PIXELS)
    ) u_span_calc (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (calc_start),
        .i_left   (i_in.rect_left),
        .i_top    (i_in.rect_top),
        .i_width  (i_in.rect_width),
        .i_height (i_in.rect_height),
        .o_done   (span_done),
        .o_span   (span)
    );

    // grid store, address is {row, col}
    tmrq_grid_mem #(
        .AW (RW + CW)
    ) u_grid_mem (
        .i_clk     (i_clk),
        .i_req     (mem_req),
        .o_rd_kind (rd_kind)
    );

    // clear sweep, handshakes, scan and result word
    tmrq_seq #(
        .GRID_ROWS (GRID_ROWS),
        .GRID_COLS (GRID_COLS)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (i_in),
        .o_out        (o_out),
        .o_calc_start (calc_start),
        .i_span_done  (span_done),
        .i_span       (span),
        .o_mem_req    (mem_req),
        .i_rd_kind    (rd_kind)
    );

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the tile map rectangle overlap query. A shadow copy
// of the tile grid is updated on every accepted write word and expands every
// accepted query word into its list of covered tiles. The bench compares each
// returned result word, field by field, against the oldest pending tile.
// Traffic runs under several sender and receiver idle mixes, with one long
// receiver hold-off that backs up the input and with pauses that let every
// pending result drain.
// ----------------------------------------------------------------------------

module tb_top;

    // Grid geometry; the dut is built with these same values.
    localparam int GRID_ROWS   = 16;
    localparam int GRID_COLS   = 32;
    localparam int TILE_PIXELS = 16;
    localparam int SPAN_MAX    = 8;

    // Run limit in ns; this is far beyond the slowest legal run.
    localparam longint RUN_LIMIT_NS = 64'd8_000_000;
    // Cycles to idle after the last result, enough for a span calculation plus a full scan.
    localparam int SETTLE_CYCLES = 80;

    // One command word as driven on the input channel.
    typedef struct {
        logic       command;
        logic [3:0] write_row;
        logic [4:0] write_col;
        logic [1:0] write_kind;
        logic [9:0] rect_left;
        logic [9:0] rect_top;
        logic [6:0] rect_width;
        logic [6:0] rect_height;
    } t_cmd_word;

    // One covered tile as returned on the output channel.
    typedef struct {
        logic [3:0] row;
        logic [4:0] col;
        logic [1:0] kind;
        logic       last;
    } t_tile_hit;

    logic i_clk;
    logic i_rst_n;

    tmrq_in_if  in_if();
    tmrq_out_if out_if();

    tile_map_rect_overlap_query #(
        .GRID_ROWS   (GRID_ROWS),
        .GRID_COLS   (GRID_COLS),
        .TILE_PIXELS (TILE_PIXELS)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // Shadow grid and the tiles still owed by the dut, oldest first.
    logic [1:0] grid_kinds [GRID_ROWS][GRID_COLS];
    t_tile_hit  hits_due [$];

    int mismatch_count = 0;

    // Idle mix, in percent of cycles; set per test.
    int src_idle_pct = 0;
    int snk_stall_pct = 0;
    // Remaining cycles of forced receiver hold-off; counted down by the receiver.
    int hold_off_left = 0;

    // ------------------------------------------------------------------------
    // Clock, and the run limit.
    // ------------------------------------------------------------------------
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #(RUN_LIMIT_NS);
        $display("tile_map_rect_overlap_query: mismatch");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Predictor: writes update the shadow grid, queries expand to tiles.
    // ------------------------------------------------------------------------

    // Last row or column of a span: clamped to the grid, then to eight tiles.
    function automatic int span_end(int first, int edge_idx, int count);
        int last_idx;
        last_idx = edge_idx;
        if (last_idx >= count)
            last_idx = count - 1;
        if (last_idx - first >= SPAN_MAX)
            last_idx = first + SPAN_MAX - 1;
        return last_idx;
    endfunction

    function automatic void apply_tile_word(t_cmd_word w);
        int        row_lo;
        int        col_lo;
        int        row_hi;
        int        col_hi;
        t_tile_hit hit;
        if (w.command == tmrq_pkg::CMD_WRITE) begin
            // fourth kind has no meaning: tile keeps its kind
            if (w.write_kind != tmrq_pkg::KIND_RSVD && w.write_row < GRID_ROWS
                    && w.write_col < GRID_COLS)
                grid_kinds[w.write_row][w.write_col] = w.write_kind;
            return;
        end
        row_lo = int'(w.rect_top) / TILE_PIXELS;
        col_lo = int'(w.rect_left) / TILE_PIXELS;
        // off-grid start gives no result at all
        if (row_lo >= GRID_ROWS || col_lo >= GRID_COLS)
            return;
        // right and bottom edges are inclusive
        row_hi = span_end(row_lo,
                          (int'(w.rect_top) + int'(w.rect_height)) / TILE_PIXELS,
                          GRID_ROWS);
        col_hi = span_end(col_lo,
                          (int'(w.rect_left) + int'(w.rect_width)) / TILE_PIXELS,
                          GRID_COLS);
        for (int r = row_lo; r <= row_hi; r++) begin
            for (int c = col_lo; c <= col_hi; c++) begin
                hit.row  = 4'(r);
                hit.col  = 5'(c);
                hit.kind = grid_kinds[r][c];
                hit.last = (r == row_hi && c == col_hi);
                hits_due.insert(hits_due.size(), hit);
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // Word builders. Fields a command ignores still carry random bits.
    // ------------------------------------------------------------------------
    function automatic t_cmd_word noise_word();
        t_cmd_word w;
        w.command     = 1'($urandom);
        w.write_row   = 4'($urandom);
        w.write_col   = 5'($urandom);
        w.write_kind  = 2'($urandom);
        w.rect_left   = 10'($urandom);
        w.rect_top    = 10'($urandom);
        w.rect_width  = 7'($urandom_range(112));
        w.rect_height = 7'($urandom_range(112));
        return w;
    endfunction

    function automatic t_cmd_word write_word(int row, int col, logic [1:0] kind);
        t_cmd_word w;
        w = noise_word();
        w.command    = tmrq_pkg::CMD_WRITE;
        w.write_row  = 4'(row);
        w.write_col  = 5'(col);
        w.write_kind = kind;
        return w;
    endfunction

    function automatic t_cmd_word query_word(int left, int top, int width, int height);
        t_cmd_word w;
        w = noise_word();
        w.command     = tmrq_pkg::CMD_QUERY;
        w.rect_left   = 10'(left);
        w.rect_top    = 10'(top);
        w.rect_width  = 7'(width);
        w.rect_height = 7'(height);
        return w;
    endfunction

    // Random traffic: mostly writes and on-grid queries with small sizes,
    // some big rectangles, some off-grid starts, some fully random words.
    function automatic t_cmd_word traffic_word();
        t_cmd_word w;
        int        pick;
        int        rows_in_use;
        int        cols_in_use;
        pick = $urandom_range(99);
        // half the traffic keeps to the top half, half to the left half, so queries find walls
        rows_in_use = $urandom_range(1) ? GRID_ROWS / 2 : GRID_ROWS;
        cols_in_use = $urandom_range(1) ? GRID_COLS / 2 : GRID_COLS;
        if (pick < 35) begin
            w = write_word($urandom_range(rows_in_use - 1), $urandom_range(cols_in_use - 1),
                           ($urandom_range(9) == 0) ? tmrq_pkg::KIND_RSVD
                                                    : 2'($urandom_range(2)));
        end else if (pick < 85) begin
            w = query_word($urandom_range(cols_in_use * TILE_PIXELS - 1),
                           $urandom_range(rows_in_use * TILE_PIXELS - 1),
                           ($urandom_range(4) == 0) ? $urandom_range(112) : $urandom_range(40),
                           ($urandom_range(4) == 0) ? $urandom_range(112) : $urandom_range(40));
        end else if (pick < 93) begin
            // start past the right or the bottom edge of the grid
            if ($urandom_range(1))
                w = query_word($urandom_range(1023, GRID_COLS * TILE_PIXELS),
                               $urandom_range(1023), $urandom_range(112), $urandom_range(112));
            else
                w = query_word($urandom_range(1023), $urandom_range(1023, GRID_ROWS * TILE_PIXELS),
                               $urandom_range(112), $urandom_range(112));
        end else begin
            w = noise_word();
        end
        return w;
    endfunction

    // ------------------------------------------------------------------------
    // Sender. Valid stays high from one word to the next unless the sender
    // idles, so it never gets two assignments in one step.
    // ------------------------------------------------------------------------
    task automatic send_word(input t_cmd_word w);
        while ($urandom_range(99) < src_idle_pct) begin
            in_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_if.valid       <= 1'b1;
        in_if.command     <= w.command;
        in_if.write_row   <= w.write_row;
        in_if.write_col   <= w.write_col;
        in_if.write_kind  <= w.write_kind;
        in_if.rect_left   <= w.rect_left;
        in_if.rect_top    <= w.rect_top;
        in_if.rect_width  <= w.rect_width;
        in_if.rect_height <= w.rect_height;
        @(posedge i_clk);
        while (!in_if.ready)
            @(posedge i_clk);
        apply_tile_word(w);
    endtask

    // Sender goes quiet until every owed tile has come back.
    task automatic wait_hits_drained();
        in_if.valid <= 1'b0;
        @(posedge i_clk);
        while (hits_due.size() != 0)
            @(posedge i_clk);
    endtask

    // ------------------------------------------------------------------------
    // Receiver: random stalls, or a forced hold-off while one is pending.
    // ------------------------------------------------------------------------
    initial begin
        out_if.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_left > 0) begin
                hold_off_left--;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= ($urandom_range(99) >= snk_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result checker: every accepted result word against the oldest tile owed.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        t_tile_hit got;
        t_tile_hit want;
        if (i_rst_n && out_if.valid && out_if.ready) begin
            got.row  = out_if.hit_row;
            got.col  = out_if.hit_col;
            got.kind = out_if.hit_kind;
            got.last = out_if.last_hit;
            if (hits_due.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("%0t: unexpected result row %0d col %0d kind %0d last %0b",
                             $realtime, got.row, got.col, got.kind, got.last);
            end else begin
                want = hits_due.pop_front();
                if (got.row !== want.row || got.col !== want.col
                        || got.kind !== want.kind || got.last !== want.last) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("%0t: want r%0d c%0d k%0d l%0b, got r%0d c%0d k%0d l%0b",
                                 $realtime, want.row, want.col, want.kind, want.last,
                                 got.row, got.col, got.kind, got.last);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------------

    // Field extremes and every corner case of the span logic.
    task automatic test_edge_cases();
        send_word(query_word(0, 0, 0, 0));             // grid starts empty
        send_word(write_word(0, 0, tmrq_pkg::KIND_WALL));
        send_word(write_word(15, 31, tmrq_pkg::KIND_SPIKE));
        send_word(write_word(7, 16, tmrq_pkg::KIND_SPIKE));
        send_word(write_word(0, 0, tmrq_pkg::KIND_RSVD));   // ignored, stays wall
        send_word(query_word(0, 0, 0, 0));
        send_word(query_word(1023, 1023, 112, 112));   // far off grid
        send_word(query_word(512, 0, 0, 0));           // first column just past
        send_word(query_word(0, 256, 5, 5));           // first row just past
        send_word(query_word(511, 255, 0, 0));         // last tile only
        send_word(query_word(496, 240, 112, 112));     // both edges clamp to grid
        send_word(query_word(400, 180, 112, 112));     // partly clamped span
        send_word(query_word(0, 0, 112, 112));         // eight by eight limit
        send_word(query_word(15, 15, 1, 1));           // inclusive edge crosses tiles
        send_word(write_word(0, 0, tmrq_pkg::KIND_EMPTY));
        send_word(write_word(15, 0, tmrq_pkg::KIND_WALL));
        send_word(write_word(0, 31, tmrq_pkg::KIND_WALL));
        send_word(query_word(0, 0, 16, 0));
        send_word(query_word(0, 240, 0, 112));         // bottom row, clamped height
        send_word(query_word(496, 0, 112, 0));         // last column, clamped width
        send_word(query_word(100, 100, 112, 112));
        wait_hits_drained();
    endtask

    task automatic test_random_traffic(int words, int src_pct, int snk_pct);
        src_idle_pct  = src_pct;
        snk_stall_pct = snk_pct;
        repeat (words)
            send_word(traffic_word());
        // sender pauses here until the dut has caught up
        wait_hits_drained();
    endtask

    // Receiver holds off while the sender keeps pushing full 8x8 queries, so
    // the scan stalls and the command channel backs up behind it.
    task automatic test_output_hold_off();
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        hold_off_left = 400;
        repeat (6)
            send_word(query_word($urandom_range(380), $urandom_range(130), 112, 112));
        repeat (10)
            send_word(traffic_word());
        wait_hits_drained();
    endtask

    // ------------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------------
    initial begin
        i_rst_n           = 1'b0;
        in_if.valid       = 1'b0;
        in_if.command     = tmrq_pkg::CMD_WRITE;
        in_if.write_row   = '0;
        in_if.write_col   = '0;
        in_if.write_kind  = tmrq_pkg::KIND_EMPTY;
        in_if.rect_left   = '0;
        in_if.rect_top    = '0;
        in_if.rect_width  = '0;
        in_if.rect_height = '0;
        for (int r = 0; r < GRID_ROWS; r++)
            for (int c = 0; c < GRID_COLS; c++)
                grid_kinds[r][c] = tmrq_pkg::KIND_EMPTY;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        // the clear sweep after reset simply shows up as a long input stall

        test_edge_cases();
        test_random_traffic(54, 0, 0);
        test_random_traffic(54, 79, 0);
        test_random_traffic(54, 0, 79);
        test_random_traffic(54, 24, 24);
        test_output_hold_off();

        snk_stall_pct = 0;
        wait_hits_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0)
            $display("tile_map_rect_overlap_query: match");
        else
            $display("tile_map_rect_overlap_query: mismatch");
        $finish;
    end

endmodule
